// ----- hdl/obls_pkg.sv -----
package obls_pkg;

   // Default sizes of the book.
   localparam int SYMBOLS_DEF    = 16;
   localparam int DEPTH_DEF      = 32;
   localparam int PRICE_BITS_DEF = 32;
   localparam int QTY_BITS_DEF   = 32;

   // Item kinds, encoded as on the request op port.
   typedef enum logic [1:0] {
      OP_SNAP  = 2'd0,
      OP_DELTA = 2'd1,
      OP_LEVEL = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // Result status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DROPPED = 2'd1;
   localparam logic [1:0] ST_OVERRUN = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   // One classified item as it waits in the command queue.
   typedef struct packed {
      op_type      op;
      logic [3:0]  sym;
      logic        side;
      logic [31:0] price;
      logic [31:0] qty;
      logic [63:0] seq;
      logic [63:0] ts;
      logic [4:0]  rank;
   } cmd_type;

   // Head of the command queue as the execution side sees it.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_type;

endpackage

// ----- hdl/obls_front.sv -----
module obls_front #(
   parameter int SYMBOLS = obls_pkg::SYMBOLS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_op,
   input  logic [3:0]          req_symbol,
   input  logic                req_side,
   input  logic [31:0]         req_price,
   input  logic [31:0]         req_qty,
   input  logic [63:0]         req_seq,
   input  logic [63:0]         req_timestamp,
   input  logic [4:0]          req_rank,
   output obls_pkg::queue_type head,
   input  logic                pop
);
   import obls_pkg::*;

   // Symbol slot folded into range for every possible four-bit input.
   logic [3:0] mod_lut [16];
   cmd_type    cmd_new;
   cmd_type    queue_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       push;

   always_comb begin
      for (int k = 0; k < 16; k++) begin
         mod_lut[k] = 4'(k % SYMBOLS);
      end
   end

   always_comb begin
      cmd_new.op    = op_type'(req_op);
      cmd_new.sym   = mod_lut[req_symbol];
      cmd_new.side  = req_side;
      cmd_new.price = req_price;
      cmd_new.qty   = req_qty;
      cmd_new.seq   = req_seq;
      cmd_new.ts    = req_timestamp;
      cmd_new.rank  = req_rank;
   end

   assign busy       = (fill_ff == 2'd2);
   assign push       = start && !busy;
   assign head.valid = (fill_ff != 2'd0);
   assign head.cmd   = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

endmodule

// ----- hdl/obls_back.sv -----
module obls_back #(
   parameter int SYMBOLS    = obls_pkg::SYMBOLS_DEF,
   parameter int DEPTH      = obls_pkg::DEPTH_DEF,
   parameter int PRICE_BITS = obls_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS   = obls_pkg::QTY_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  obls_pkg::queue_type head,
   output logic                pop,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [31:0]         rsp_level_price,
   output logic [31:0]         rsp_level_qty,
   output logic [5:0]          rsp_level_count,
   output logic [63:0]         rsp_book_seq,
   output logic [63:0]         rsp_book_time,
   output logic                rsp_baseline_valid
);
   import obls_pkg::*;

   localparam int SW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int DW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = PRICE_BITS + QTY_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_EXEC, S_CLR, S_RDLV, S_SRD, S_SCMP, S_ACT,
      S_RRD, S_RWR, S_LRD, S_LWR, S_FIN
   } state_type;

   typedef enum logic [1:0] {
      M_NONE, M_SNAP, M_DELTA, M_DROP
   } mode_type;

   // Level memory, count memory and per-symbol header memories.
   logic [EW-1:0] lvl_mem [2**(SW+1+DW)];
   logic [CW-1:0] cnt_mem [2**(SW+1)];
   logic [63:0]   seq_mem [2**SW];
   logic [63:0]   ts_mem  [2**SW];

   logic [EW-1:0] lvl_q_ff;
   logic [CW-1:0] cnt_q_ff;
   logic [63:0]   seq_q_ff;
   logic [63:0]   ts_q_ff;

   state_type     state_ff;
   mode_type      mode_ff;
   cmd_type       cmd_ff;
   logic [SW-1:0] sym_ff;
   logic [SW-1:0] cur_sym_ff;
   logic [SYMBOLS-1:0] valid_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] j_ff;
   logic [CW-1:0] pos_ff;
   logic [CW-1:0] eq_ff;
   logic          pos_found_ff;
   logic          eq_found_ff;
   logic [CW-1:0] newcnt_ff;
   logic          fin_ins_ff;
   logic [1:0]    st_ff;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [31:0]   rsp_price_ff;
   logic [31:0]   rsp_qty_ff;
   logic [5:0]    rsp_count_ff;
   logic [63:0]   rsp_seq_ff;
   logic [63:0]   rsp_time_ff;
   logic          rsp_base_ff;

   logic                  vld;
   logic [CW-1:0]         n_cur;
   logic [63:0]           seq_cur;
   logic [63:0]           ts_cur;
   logic [PRICE_BITS-1:0] new_price;
   logic [QTY_BITS-1:0]   new_qty;
   logic [PRICE_BITS-1:0] ent_price;
   logic                  after;
   logic [CW-1:0]         ins_n;
   logic [CW-1:0]         j_in;
   logic [DW-1:0]         rd_idx;
   logic                  lvl_we;
   logic [DW-1:0]         wr_idx;
   logic [EW-1:0]         lvl_wd;
   logic                  cnt_we;
   logic                  cnt_side;
   logic [CW-1:0]         cnt_wd;
   logic                  hdr_we;
   logic                  rank_ok;
   logic                  upd_open;
   logic                  rsp_fire;

   assign vld       = valid_ff[sym_ff];
   assign n_cur     = vld ? cnt_q_ff : '0;
   assign seq_cur   = vld ? seq_q_ff : '0;
   assign ts_cur    = vld ? ts_q_ff : '0;
   assign new_price = PRICE_BITS'(cmd_ff.price);
   assign new_qty   = QTY_BITS'(cmd_ff.qty);
   assign ent_price = lvl_q_ff[EW-1:QTY_BITS];
   assign after     = cmd_ff.side ? (ent_price > new_price) : (ent_price < new_price);
   assign ins_n     = (n_ff == CW'(DEPTH)) ? CW'(DEPTH - 1) : n_ff;
   assign j_in      = j_ff + CW'(1);
   assign pop       = (state_ff == S_IDLE) && head.valid;
   assign rank_ok   = 10'(cmd_ff.rank) < 10'(n_cur);
   assign upd_open  = (mode_ff == M_SNAP) || (mode_ff == M_DELTA);

   // A response leaves in the cycle after any state that finishes an item.
   always_comb begin
      case (state_ff)
         S_EXEC: rsp_fire = (cmd_ff.op == OP_DELTA) ||
                            (cmd_ff.op == OP_READ && !rank_ok) ||
                            (cmd_ff.op == OP_LEVEL && !upd_open);
         S_CLR, S_RDLV, S_FIN: rsp_fire = 1'b1;
         default: rsp_fire = 1'b0;
      endcase
   end

   // Memory port control.
   always_comb begin
      rd_idx   = idx_ff[DW-1:0];
      lvl_we   = 1'b0;
      wr_idx   = pos_ff[DW-1:0];
      lvl_wd   = lvl_q_ff;
      cnt_we   = 1'b0;
      cnt_side = cmd_ff.side;
      cnt_wd   = newcnt_ff;
      hdr_we   = 1'b0;
      case (state_ff)
         S_EXEC: begin
            rd_idx = DW'(cmd_ff.rank);
            if (cmd_ff.op == OP_SNAP) begin
               cnt_we   = 1'b1;
               cnt_side = 1'b0;
               cnt_wd   = '0;
               hdr_we   = 1'b1;
            end else if (cmd_ff.op == OP_DELTA) begin
               hdr_we = vld;
            end
         end
         S_CLR: begin
            cnt_we   = 1'b1;
            cnt_side = 1'b1;
            cnt_wd   = '0;
         end
         S_RRD: rd_idx = j_ff[DW-1:0];
         S_RWR: begin
            lvl_we = 1'b1;
            wr_idx = j_in[DW-1:0];
         end
         S_LRD: rd_idx = j_in[DW-1:0];
         S_LWR: begin
            lvl_we = 1'b1;
            wr_idx = j_ff[DW-1:0];
         end
         S_FIN: begin
            lvl_we = fin_ins_ff;
            lvl_wd = {new_price, new_qty};
            cnt_we = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (lvl_we) begin
         lvl_mem[{sym_ff, cmd_ff.side, wr_idx}] <= lvl_wd;
      end
      lvl_q_ff <= lvl_mem[{sym_ff, cmd_ff.side, rd_idx}];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[{sym_ff, cnt_side}] <= cnt_wd;
      end
      cnt_q_ff <= cnt_mem[{sym_ff, cmd_ff.side}];
   end

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         seq_mem[sym_ff] <= cmd_ff.seq;
         ts_mem[sym_ff]  <= cmd_ff.ts;
      end
      seq_q_ff <= seq_mem[sym_ff];
      ts_q_ff  <= ts_mem[sym_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_NONE;
         cur_sym_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_fire;
         case (state_ff)
            S_IDLE: begin
               if (head.valid) begin
                  cmd_ff   <= head.cmd;
                  sym_ff   <= (head.cmd.op == OP_LEVEL) ? cur_sym_ff : SW'(head.cmd.sym);
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: state_ff <= S_EXEC;
            S_EXEC: begin
               rsp_price_ff  <= '0;
               rsp_qty_ff    <= '0;
               rsp_count_ff  <= 6'(n_cur);
               // A delta on a book with a baseline reports its own header.
               rsp_seq_ff    <= (cmd_ff.op == OP_DELTA && vld) ? cmd_ff.seq : seq_cur;
               rsp_time_ff   <= (cmd_ff.op == OP_DELTA && vld) ? cmd_ff.ts : ts_cur;
               rsp_base_ff   <= vld;
               n_ff          <= n_cur;
               case (cmd_ff.op)
                  OP_SNAP: begin
                     rsp_status_ff    <= ST_OK;
                     valid_ff[sym_ff] <= 1'b1;
                     cur_sym_ff       <= sym_ff;
                     mode_ff          <= M_SNAP;
                     state_ff         <= S_CLR;
                  end
                  OP_DELTA: begin
                     cur_sym_ff    <= sym_ff;
                     state_ff      <= S_IDLE;
                     mode_ff       <= vld ? M_DELTA : M_DROP;
                     rsp_status_ff <= vld ? ST_OK : ST_DROPPED;
                  end
                  OP_READ: begin
                     rsp_status_ff <= rank_ok ? ST_OK : ST_RANGE;
                     state_ff      <= rank_ok ? S_RDLV : S_IDLE;
                  end
                  default: begin
                     if (upd_open) begin
                        rsp_status_ff <= ST_OK;
                        idx_ff        <= '0;
                        pos_ff        <= n_cur;
                        eq_ff         <= '0;
                        pos_found_ff  <= 1'b0;
                        eq_found_ff   <= 1'b0;
                        state_ff      <= (n_cur == '0) ? S_ACT : S_SRD;
                     end else begin
                        rsp_status_ff <= ST_DROPPED;
                        state_ff      <= S_IDLE;
                     end
                  end
               endcase
            end
            S_CLR: begin
               rsp_status_ff <= ST_OK;
               rsp_count_ff  <= '0;
               rsp_seq_ff    <= cmd_ff.seq;
               rsp_time_ff   <= cmd_ff.ts;
               rsp_base_ff   <= 1'b1;
               state_ff      <= S_IDLE;
            end
            S_RDLV: begin
               rsp_price_ff <= 32'(lvl_q_ff[EW-1:QTY_BITS]);
               rsp_qty_ff   <= 32'(lvl_q_ff[QTY_BITS-1:0]);
               state_ff     <= S_IDLE;
            end
            S_SRD: state_ff <= S_SCMP;
            S_SCMP: begin
               if (!eq_found_ff && ent_price == new_price) begin
                  eq_found_ff <= 1'b1;
                  eq_ff       <= idx_ff;
               end
               if (!pos_found_ff && after) begin
                  pos_found_ff <= 1'b1;
                  pos_ff       <= idx_ff;
               end
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= (idx_ff + CW'(1) == n_ff) ? S_ACT : S_SRD;
            end
            S_ACT: begin
               if (mode_ff == M_DELTA && new_qty == '0) begin
                  // Removal: close the gap left by the matched level.
                  st_ff      <= ST_OK;
                  fin_ins_ff <= 1'b0;
                  newcnt_ff  <= eq_found_ff ? n_ff - CW'(1) : n_ff;
                  j_ff       <= eq_ff;
                  state_ff   <= (eq_found_ff && eq_ff + CW'(1) < n_ff) ? S_LRD : S_FIN;
               end else if (mode_ff == M_DELTA && eq_found_ff) begin
                  st_ff      <= ST_OK;
                  fin_ins_ff <= 1'b1;
                  newcnt_ff  <= n_ff;
                  pos_ff     <= eq_ff;
                  state_ff   <= S_FIN;
               end else if (n_ff == CW'(DEPTH) && pos_ff == n_ff) begin
                  // The new level would be the worst of a full side.
                  st_ff      <= ST_OVERRUN;
                  fin_ins_ff <= 1'b0;
                  newcnt_ff  <= n_ff;
                  state_ff   <= S_FIN;
               end else begin
                  st_ff      <= (n_ff == CW'(DEPTH)) ? ST_OVERRUN : ST_OK;
                  fin_ins_ff <= 1'b1;
                  newcnt_ff  <= ins_n + CW'(1);
                  j_ff       <= ins_n - CW'(1);
                  state_ff   <= (ins_n > pos_ff) ? S_RRD : S_FIN;
               end
            end
            S_RRD: state_ff <= S_RWR;
            S_RWR: begin
               if (j_ff == pos_ff) begin
                  state_ff <= S_FIN;
               end else begin
                  j_ff     <= j_ff - CW'(1);
                  state_ff <= S_RRD;
               end
            end
            S_LRD: state_ff <= S_LWR;
            S_LWR: begin
               if (j_in == newcnt_ff) begin
                  state_ff <= S_FIN;
               end else begin
                  j_ff     <= j_in;
                  state_ff <= S_LRD;
               end
            end
            S_FIN: begin
               rsp_status_ff <= st_ff;
               rsp_price_ff  <= '0;
               rsp_qty_ff    <= '0;
               rsp_count_ff  <= 6'(newcnt_ff);
               rsp_seq_ff    <= seq_cur;
               rsp_time_ff   <= ts_cur;
               rsp_base_ff   <= vld;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_level_price    = rsp_price_ff;
   assign rsp_level_qty      = rsp_qty_ff;
   assign rsp_level_count    = rsp_count_ff;
   assign rsp_book_seq       = rsp_seq_ff;
   assign rsp_book_time      = rsp_time_ff;
   assign rsp_baseline_valid = rsp_base_ff;

endmodule

// ----- hdl/order_book_level_store_top.sv -----
// Channel    | Ports                          | Handshake
// request    | start, busy, req_*             | item taken when start is high and busy is low
// response   | rsp_valid, rsp_*               | one-cycle strobe per item, cannot be held off
//
// Every item yields exactly one response. Begin items, reads and dropped level items
// pass through the load and execute states; a snapshot then clears its other side and
// an in-range read fetches its level. A level change scans the held levels of its
// side, a read state and a compare state per level, then moves the levels behind the
// insert or removal point, a read state and a write state per level. Reset is
// synchronous and clears all books at once: only the per-symbol snapshot flags are
// flip-flops, everything else is read as empty until a snapshot writes it. A two-item
// queue decouples intake from execution, and busy rises only when that queue is full.
module order_book_level_store_top #(
   parameter int SYMBOLS    = obls_pkg::SYMBOLS_DEF,
   parameter int DEPTH      = obls_pkg::DEPTH_DEF,
   parameter int PRICE_BITS = obls_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS   = obls_pkg::QTY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_symbol,
   input  logic        req_side,
   input  logic [31:0] req_price,
   input  logic [31:0] req_qty,
   input  logic [63:0] req_seq,
   input  logic [63:0] req_timestamp,
   input  logic [4:0]  req_rank,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_level_price,
   output logic [31:0] rsp_level_qty,
   output logic [5:0]  rsp_level_count,
   output logic [63:0] rsp_book_seq,
   output logic [63:0] rsp_book_time,
   output logic        rsp_baseline_valid
);
   import obls_pkg::*;

   // Head of the command queue and the pop that the execution side returns.
   queue_type head;
   logic      pop;

   // The front end decodes the item kind, folds the symbol slot into range and queues the item.
   obls_front #(
      .SYMBOLS(SYMBOLS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_symbol    (req_symbol),
      .req_side      (req_side),
      .req_price     (req_price),
      .req_qty       (req_qty),
      .req_seq       (req_seq),
      .req_timestamp (req_timestamp),
      .req_rank      (req_rank),
      .head          (head),
      .pop           (pop)
   );

   // The back end holds the books and runs the search and shift sequences.
   obls_back #(
      .SYMBOLS    (SYMBOLS),
      .DEPTH      (DEPTH),
      .PRICE_BITS (PRICE_BITS),
      .QTY_BITS   (QTY_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_level_price    (rsp_level_price),
      .rsp_level_qty      (rsp_level_qty),
      .rsp_level_count    (rsp_level_count),
      .rsp_book_seq       (rsp_book_seq),
      .rsp_book_time      (rsp_book_time),
      .rsp_baseline_valid (rsp_baseline_valid)
   );

endmodule

// ----- hdl/obls_checker.sv -----
module obls_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_level_price,
   input logic [31:0] rsp_level_qty
);
   import obls_pkg::*;

   // Every state that finishes an item returns to idle, so two responses never come back to back.
   a_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("responses on consecutive cycles");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("activity right after reset");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_RANGE |-> rsp_level_price == '0 && rsp_level_qty == '0)
      else $error("out-of-range read returned a level");

   a_busy_needs_item: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a new item");

endmodule

bind order_book_level_store_top obls_checker u_obls_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_level_price (rsp_level_price),
   .rsp_level_qty   (rsp_level_qty)
);

// ----- tb/order_book_level_store_checker.sv -----
`timescale 1ns / 1ps
module order_book_level_store_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_symbol,
   input  logic        req_side,
   input  logic [31:0] req_price,
   input  logic [31:0] req_qty,
   input  logic [63:0] req_seq,
   input  logic [63:0] req_timestamp,
   input  logic [4:0]  req_rank,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_level_price,
   input  logic [31:0] rsp_level_qty,
   input  logic [5:0]  rsp_level_count,
   input  logic [63:0] rsp_book_seq,
   input  logic [63:0] rsp_book_time,
   input  logic        rsp_baseline_valid,
   output int          errors,
   output int          pending
);
   import obls_pkg::*;

   localparam int NSYM = SYMBOLS_DEF;
   localparam int NLEV = DEPTH_DEF;

   typedef enum logic [1:0] {
      UPD_NONE, UPD_SNAP, UPD_DELTA, UPD_DROP
   } upd_mode_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] price;
      logic [31:0] qty;
      logic [5:0]  count;
      logic [63:0] seq;
      logic [63:0] ts;
      logic        valid;
   } book_reply_type;

   logic [31:0]    lv_price [NSYM][2][NLEV];
   logic [31:0]    lv_qty   [NSYM][2][NLEV];
   int             lv_count [NSYM][2];
   logic           has_base [NSYM];
   logic [63:0]    book_seq [NSYM];
   logic [63:0]    book_ts  [NSYM];
   logic [3:0]     open_sym;
   upd_mode_type   open_mode;
   book_reply_type replies_due [$];

   assign pending = replies_due.size();

   // Sorted insert behind equal prices; returns 1 when a level fell off.
   function automatic logic place_level(int s, int sd, logic [31:0] p, logic [31:0] q);
      int n;
      int pos;
      logic over;
      n = lv_count[s][sd];
      pos = 0;
      over = 1'b0;
      while (pos < n && !(sd ? lv_price[s][sd][pos] > p : lv_price[s][sd][pos] < p))
         pos++;
      if (n >= NLEV) begin
         if (pos >= NLEV) return 1'b1;
         n = NLEV - 1;
         over = 1'b1;
      end
      for (int i = n; i > pos; i--) begin
         lv_price[s][sd][i] = lv_price[s][sd][i-1];
         lv_qty[s][sd][i]   = lv_qty[s][sd][i-1];
      end
      lv_price[s][sd][pos] = p;
      lv_qty[s][sd][pos]   = q;
      lv_count[s][sd] = n + 1;
      return over;
   endfunction

   function automatic logic [1:0] apply_delta(int s, int sd, logic [31:0] p, logic [31:0] q);
      int n;
      int i;
      n = lv_count[s][sd];
      i = 0;
      while (i < n && lv_price[s][sd][i] != p) i++;
      if (q == '0) begin
         if (i < n) begin
            for (int k = i; k < n - 1; k++) begin
               lv_price[s][sd][k] = lv_price[s][sd][k+1];
               lv_qty[s][sd][k]   = lv_qty[s][sd][k+1];
            end
            lv_count[s][sd] = n - 1;
         end
         return ST_OK;
      end
      if (i < n) begin
         lv_qty[s][sd][i] = q;
         return ST_OK;
      end
      return place_level(s, sd, p, q) ? ST_OVERRUN : ST_OK;
   endfunction

   function automatic book_reply_type book_update(op_type op, int s, int sd, logic [31:0] p,
                                                  logic [31:0] q, logic [63:0] sq,
                                                  logic [63:0] ts, int rk);
      book_reply_type r;
      r = '0;
      case (op)
         OP_SNAP: begin
            lv_count[s][0] = 0;
            lv_count[s][1] = 0;
            has_base[s] = 1'b1;
            book_seq[s] = sq;
            book_ts[s] = ts;
            open_sym = 4'(s);
            open_mode = UPD_SNAP;
         end
         OP_DELTA: begin
            open_sym = 4'(s);
            if (has_base[s]) begin
               book_seq[s] = sq;
               book_ts[s] = ts;
               open_mode = UPD_DELTA;
            end else begin
               open_mode = UPD_DROP;
               r.status = ST_DROPPED;
            end
         end
         OP_LEVEL: begin
            s = int'(open_sym);
            if (open_mode == UPD_SNAP)
               r.status = place_level(s, sd, p, q) ? ST_OVERRUN : ST_OK;
            else if (open_mode == UPD_DELTA)
               r.status = apply_delta(s, sd, p, q);
            else
               r.status = ST_DROPPED;
         end
         default: begin
            if (rk < lv_count[s][sd]) begin
               r.price = lv_price[s][sd][rk];
               r.qty   = lv_qty[s][sd][rk];
            end else begin
               r.status = ST_RANGE;
            end
         end
      endcase
      r.count = 6'(lv_count[s][sd]);
      r.seq   = book_seq[s];
      r.ts    = book_ts[s];
      r.valid = has_base[s];
      return r;
   endfunction

   always @(posedge clock) begin
      book_reply_type want;
      book_reply_type got;
      if (reset) begin
         errors <= 0;
         replies_due.delete();
         open_sym = '0;
         open_mode = UPD_NONE;
         for (int s = 0; s < NSYM; s++) begin
            lv_count[s][0] = 0;
            lv_count[s][1] = 0;
            has_base[s] = 1'b0;
            book_seq[s] = '0;
            book_ts[s] = '0;
         end
      end else begin
         if (rsp_valid) begin
            got = {rsp_status, rsp_level_price, rsp_level_qty, rsp_level_count,
                   rsp_book_seq, rsp_book_time, rsp_baseline_valid};
            if (replies_due.size() == 0) begin
               $display("%0t: unexpected response, actual %p", $time, got);
               errors <= errors + 1;
            end else begin
               want = replies_due.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                  errors <= errors + 1;
               end
            end
         end
         if (start && !busy)
            replies_due.insert(replies_due.size(),
                               book_update(op_type'(req_op), int'(req_symbol),
                                           int'(req_side), req_price, req_qty, req_seq,
                                           req_timestamp, int'(req_rank)));
      end
   end

endmodule

// ----- tb/order_book_level_store_top_tb.sv -----
`timescale 1ns / 1ps
module order_book_level_store_top_tb;
   import obls_pkg::*;

   // A level change on a full side scans and moves up to 32 levels, and two
   // items can wait in the queue, so this quiet-cycle limit is generous.
   localparam int QUIET_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 800;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_op;
   logic [3:0]  req_symbol;
   logic        req_side;
   logic [31:0] req_price;
   logic [31:0] req_qty;
   logic [63:0] req_seq;
   logic [63:0] req_timestamp;
   logic [4:0]  req_rank;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_level_price;
   logic [31:0] rsp_level_qty;
   logic [5:0]  rsp_level_count;
   logic [63:0] rsp_book_seq;
   logic [63:0] rsp_book_time;
   logic        rsp_baseline_valid;
   int          errors;
   int          pending;
   int          quiet_cycles;

   // Symbols that have had a snapshot; deltas mostly target these.
   logic        snapped [16];

   order_book_level_store_top dut (.*);
   order_book_level_store_checker checker_inst (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // The watchdog restarts whenever an item goes in or a response comes out.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Present one item from the falling edge and hold it until it is taken. Start
   // stays high into the next item when that follows without a gap.
   task automatic send_item(op_type op, logic [3:0] sym, logic sd, logic [31:0] p,
                            logic [31:0] q, logic [63:0] sq, logic [63:0] ts,
                            logic [4:0] rk);
      start         <= 1'b1;
      req_op        <= op;
      req_symbol    <= sym;
      req_side      <= sd;
      req_price     <= p;
      req_qty       <= q;
      req_seq       <= sq;
      req_timestamp <= ts;
      req_rank      <= rk;
      do
         @(posedge clock);
      while (busy);
      @(negedge clock);
      if (op == OP_SNAP) snapped[sym] = 1'b1;
   endtask

   task automatic pause_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Prices are mostly drawn from a narrow band so that deltas hit held levels.
   function automatic logic [31:0] pick_price();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return 32'd1000 + $urandom_range(0, 40);
   endfunction

   function automatic logic [31:0] pick_qty();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return $urandom;
         default: return $urandom_range(1, 500);
      endcase
   endfunction

   initial begin
      int sent;
      int burst;
      logic [3:0] sym;
      start = 1'b0;
      reset = 1'b1;
      req_op = OP_SNAP;
      req_symbol = '0;
      req_side = 1'b0;
      req_price = '0;
      req_qty = '0;
      req_seq = '0;
      req_timestamp = '0;
      req_rank = '0;
      quiet_cycles = 0;
      foreach (snapped[i]) snapped[i] = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: reads and levels on an empty book, a delta with no
      // baseline, then a snapshot with extreme fields and equal prices, delta
      // updates, removals of present and absent prices, and an out-of-range read.
      send_item(OP_READ, 4'd15, 1'b1, '0, '0, '0, '0, 5'd31);
      send_item(OP_LEVEL, 4'd0, 1'b0, 32'd5, 32'd5, '0, '0, '0);
      send_item(OP_DELTA, 4'd3, 1'b0, '0, '0, '1, '1, '0);
      send_item(OP_LEVEL, 4'd0, 1'b1, 32'd7, 32'd7, '0, '0, '0);
      send_item(OP_SNAP, 4'd15, 1'b0, '0, '0, '1, '1, '0);
      send_item(OP_LEVEL, 4'd0, 1'b0, '1, '1, '0, '0, '0);
      send_item(OP_LEVEL, 4'd0, 1'b0, 32'd0, 32'd0, '0, '0, '0);
      send_item(OP_LEVEL, 4'd0, 1'b0, 32'd50, 32'd1, '0, '0, '0);
      send_item(OP_LEVEL, 4'd0, 1'b0, 32'd50, 32'd2, '0, '0, '0);
      send_item(OP_LEVEL, 4'd0, 1'b1, '1, 32'd3, '0, '0, '0);
      send_item(OP_LEVEL, 4'd0, 1'b1, 32'd0, '1, '0, '0, '0);
      send_item(OP_DELTA, 4'd15, 1'b0, 32'd0, 32'd0, '0, '0, '0);
      send_item(OP_LEVEL, 4'd0, 1'b0, 32'd50, 32'd9, '0, '0, '0);
      send_item(OP_LEVEL, 4'd0, 1'b0, 32'd77, 32'd0, '0, '0, '0);
      send_item(OP_LEVEL, 4'd0, 1'b0, 32'd0, 32'd0, '0, '0, '0);
      send_item(OP_LEVEL, 4'd0, 1'b1, 32'd20, 32'd4, '0, '0, '0);
      send_item(OP_READ, 4'd15, 1'b0, '0, '0, '0, '0, 5'd0);
      send_item(OP_READ, 4'd15, 1'b0, '0, '0, '0, '0, 5'd1);
      send_item(OP_READ, 4'd15, 1'b1, '0, '0, '0, '0, 5'd2);
      send_item(OP_READ, 4'd15, 1'b1, '0, '0, '0, '0, 5'd31);

      // Fill one ask side past its depth so that the worst level falls off when
      // a new level lands inside the full book.
      send_item(OP_SNAP, 4'd1, 1'b0, '0, '0, rand64(), rand64(), '0);
      for (int i = 0; i < 34; i++)
         send_item(OP_LEVEL, 4'd0, 1'b1, 32'd100 + (i % 2 ? 200 - i : i), $urandom,
                   '0, '0, '0);
      send_item(OP_READ, 4'd1, 1'b1, '0, '0, '0, '0, 5'd31);

      // Let everything drain once before the random part.
      pause_sender(1);
      while (pending != 0) @(negedge clock);

      // Random part: mostly snapshots or deltas followed by level runs, with
      // reads and stray items mixed in, sent in bursts with random gaps.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 4);
         sym = 4'($urandom_range(0, 15));
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               send_item(OP_SNAP, sym, 1'($urandom), $urandom, $urandom, rand64(),
                         rand64(), 5'($urandom));
               burst = $urandom_range(2, 12);
               for (int i = 0; i < burst; i++)
                  send_item(OP_LEVEL, 4'($urandom), 1'($urandom), pick_price(),
                            pick_qty(), rand64(), rand64(), 5'($urandom));
               sent += burst + 1;
            end
            3, 4, 5: begin
               if (!snapped[sym] && $urandom_range(0, 3) != 0)
                  sym = 4'd15;
               send_item(OP_DELTA, sym, 1'($urandom), $urandom, $urandom, rand64(),
                         rand64(), 5'($urandom));
               burst = $urandom_range(1, 10);
               for (int i = 0; i < burst; i++)
                  send_item(OP_LEVEL, 4'($urandom), 1'($urandom), pick_price(),
                            pick_qty(), rand64(), rand64(), 5'($urandom));
               sent += burst + 1;
            end
            6, 7, 8: begin
               for (int i = 0; i < burst; i++)
                  send_item(OP_READ, 4'($urandom), 1'($urandom), $urandom, $urandom,
                            rand64(), rand64(),
                            ($urandom_range(0, 12) == 0) ? 5'($urandom)
                                                         : 5'($urandom_range(0, 8)));
               sent += burst;
            end
            default: begin
               send_item(op_type'($urandom_range(0, 3)), 4'($urandom), 1'($urandom),
                         $urandom, $urandom, rand64(), rand64(), 5'($urandom));
               sent += 1;
            end
         endcase
         if ($urandom_range(0, 2) == 0)
            pause_sender($urandom_range(1, 30));
         if ($urandom_range(0, 60) == 0) begin
            pause_sender(1);
            while (pending != 0) @(negedge clock);
         end
      end

      pause_sender(1);
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
